/* rtl/esch_pkg.sv */
// ----------------------------------------------------------------------------
// esch_pkg
// shared types and constants of the periodic task scheduler
// ----------------------------------------------------------------------------
package esch_pkg;

  // width of the tick counter, which advances on each accepted tick request
  localparam int unsigned TICK_W = 32;

  // widths of the request and result fields
  localparam int unsigned FIELD_W = 8;
  localparam int unsigned ID_W    = 5;

  // scheduling policy codes
  localparam logic POLICY_RM  = 1'b0;
  localparam logic POLICY_EDF = 1'b1;

  // request kinds carried in tuser
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ADD  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_DIV,
    S_SEL,
    S_UPD,
    S_DONE
  } esch_state_e;

endpackage

/* rtl/edf_rm_task_scheduler.sv */
// ----------------------------------------------------------------------------
// edf_rm_task_scheduler
// periodic task table scheduler, earliest deadline first or rate monotonic
// ----------------------------------------------------------------------------
// Each request is either a tick (tuser 0) or the addition of a periodic task
// (tuser 1, cost and period in tdata) and yields exactly one result. The task
// table is a single-port-read memory of MAX_TASKS entries that a small
// sequencer walks one entry per cycle. A tick makes two passes over the N
// tasks in the table. One pass feeds the selection comparator. A second pass
// reads, updates and writes back every entry. Each pass issues N reads, waits
// for the registered read data and closes, and then the result is loaded into
// the output register. An add runs the 32-step bit-serial remainder unit that
// aligns the new task's release phase to the current tick count; a rejected
// add goes straight to its result. Release is tracked through a per-task
// phase counter that equals the tick count modulo the period, so no division
// is done on ticks; on wrap of the 32-bit tick count every phase restarts at
// zero. The input is not ready while a request is being worked on and is
// ready again at the edge that presents the result; a finished result waits
// in the output register while the next request is already accepted. The
// policy register is written through cfg_we_i and cfg_wdata_i; the user must
// write it only while the block is idle, and the block does not enforce this.
// ----------------------------------------------------------------------------
module edf_rm_task_scheduler
  import esch_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TIME_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // policy register: 0 rate monotonic, 1 earliest deadline first
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // task_cost[7:0], task_period[15:8]
  input  logic        s_axis_tuser,  // mode
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // chosen_id[4:0], job_finished[5],
                                     // add_accepted[6], zero[7]
);

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned ExtW = 17;
  localparam logic [ExtW-1:0] TimeMask = ExtW'((1 << TIME_BITS) - 1);

  // one task table entry
  typedef struct packed {
    logic [TIME_BITS-1:0] cost;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] rem;
    logic [TIME_BITS-1:0] deadline;
    logic [TIME_BITS-1:0] phase;
    logic                 done;
  } entry_t;

  esch_state_e state_q, state_d;

  logic              use_edf_q;
  logic [TICK_W-1:0] tick_q;
  logic              wrap_q;
  logic [CntW-1:0]   task_count_q;

  // scan control
  logic [CntW-1:0]   cnt_q;
  logic              pend_q;
  logic [IdxW-1:0]   pidx_q;
  logic              issue;
  logic              scan_end;

  // latched add request
  logic [TIME_BITS-1:0] add_cost_q;
  logic [TIME_BITS-1:0] add_per_q;

  // result held until the output register is free
  logic [ID_W-1:0] res_id_q;
  logic            res_fin_q;
  logic            res_acc_q;

  logic            out_vld_q;
  logic [7:0]      out_data_q;

  // table memory
  entry_t          mem_q [MAX_TASKS];
  entry_t          rdata_q;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;

  // request decode
  logic            in_acc;
  logic [ExtW-1:0] cost_ext;
  logic [ExtW-1:0] per_ext;
  logic            add_ok;

  // shared units
  logic                 mod_start;
  logic                 mod_done;
  logic [TIME_BITS-1:0] mod_rem;
  logic                 pick_clear;
  logic                 pick_en;
  logic                 best_vld;
  logic [IdxW-1:0]      best_idx;

  // entry update
  entry_t               upd;
  logic                 is_sel;
  logic                 upd_fin;
  logic [TIME_BITS-1:0] rem_dec;
  logic [TIME_BITS-1:0] dl_dec;
  logic [TIME_BITS:0]   phase_inc;
  logic [TIME_BITS-1:0] phase_nxt;

  logic out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cost_ext = {{(ExtW - FIELD_W){1'b0}}, s_axis_tdata[7:0]};
  assign per_ext  = {{(ExtW - FIELD_W){1'b0}}, s_axis_tdata[15:8]};

  // reject zero values, cost not below period, values too wide, full table
  assign add_ok = (cost_ext != '0) && (per_ext != '0) && (cost_ext < per_ext) &&
                  (cost_ext <= TimeMask) && (per_ext <= TimeMask) &&
                  (task_count_q < CntW'(MAX_TASKS));

  assign issue    = (cnt_q < task_count_q);
  assign scan_end = !issue && !pend_q;
  assign out_free = !out_vld_q || m_axis_tready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == MODE_TICK) begin
            state_d = S_SEL;
          end else if (add_ok) begin
            state_d = S_ADD_DIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ADD_DIV: begin
        if (mod_done) begin
          state_d = S_DONE;
        end
      end
      S_SEL: begin
        if (scan_end) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mod_start     = 1'b0;
    pick_clear    = 1'b0;
    pick_en       = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        pick_clear    = 1'b1;
        mod_start     = in_acc && (s_axis_tuser == MODE_ADD) && add_ok;
      end
      S_SEL: begin
        pick_en = pend_q;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------- entry update
  // charge the chosen task, age deadlines on busy ticks, then release
  always_comb begin
    upd     = rdata_q;
    is_sel  = best_vld && (pidx_q == best_idx);
    rem_dec = rdata_q.rem;
    if (is_sel && (rdata_q.rem != '0)) begin
      rem_dec = rdata_q.rem - 1'b1;
    end
    dl_dec = rdata_q.deadline;
    if (best_vld) begin
      if (rdata_q.deadline != '0) begin
        dl_dec = rdata_q.deadline - 1'b1;
      end
      if (dl_dec == '0) begin
        dl_dec = rdata_q.period;
      end
    end
    upd_fin      = is_sel && (rem_dec == '0);
    upd.rem      = rem_dec;
    upd.deadline = dl_dec;
    upd.done     = rdata_q.done || upd_fin;
    // phase tracks tick count modulo period
    phase_inc = {1'b0, rdata_q.phase} + 1'b1;
    if (wrap_q || (phase_inc == {1'b0, rdata_q.period})) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = phase_inc[TIME_BITS-1:0];
    end
    upd.phase = phase_nxt;
    if (phase_nxt == '0) begin
      upd.done     = 1'b0;
      upd.rem      = rdata_q.cost;
      upd.deadline = rdata_q.period;
    end
  end

  // write port: new task on add, updated entry during the update pass
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pidx_q;
    wr_data = upd;
    if (state_q == S_ADD_DIV) begin
      wr_en            = mod_done;
      wr_addr          = task_count_q[IdxW-1:0];
      wr_data.cost     = add_cost_q;
      wr_data.period   = add_per_q;
      wr_data.rem      = add_cost_q;
      wr_data.deadline = add_per_q;
      wr_data.phase    = mod_rem;
      wr_data.done     = 1'b0;
    end else if (state_q == S_UPD) begin
      wr_en = pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_q <= mem_q[cnt_q[IdxW-1:0]];
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      use_edf_q    <= POLICY_RM;
      tick_q       <= '0;
      wrap_q       <= 1'b0;
      task_count_q <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        use_edf_q <= cfg_wdata_i;
      end
      if (in_acc && (s_axis_tuser == MODE_TICK)) begin
        tick_q <= tick_q + 1'b1;
        wrap_q <= (tick_q == '1);
      end
      if ((state_q == S_ADD_DIV) && mod_done) begin
        task_count_q <= task_count_q + 1'b1;
      end
      // scan counter restarts for each pass
      if ((state_q == S_SEL) || (state_q == S_UPD)) begin
        if (scan_end) begin
          cnt_q <= '0;
        end else if (issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
        pend_q <= issue;
      end else begin
        cnt_q  <= '0;
        pend_q <= 1'b0;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q[IdxW-1:0];
    if (in_acc) begin
      add_cost_q <= cost_ext[TIME_BITS-1:0];
      add_per_q  <= per_ext[TIME_BITS-1:0];
      res_id_q   <= '0;
      res_fin_q  <= 1'b0;
      res_acc_q  <= (s_axis_tuser == MODE_ADD) && add_ok;
    end
    if ((state_q == S_SEL) && scan_end && best_vld) begin
      res_id_q <= ID_W'(32'(best_idx) + 32'd1);
    end
    if ((state_q == S_UPD) && pend_q && is_sel) begin
      res_fin_q <= upd_fin;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_data_q <= {1'b0, res_acc_q, res_fin_q, res_id_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ----------------------------------------------------------- shared units
  esch_mod_unit #(
    .DIV_W (TIME_BITS)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (tick_q),
    .divisor_i  (per_ext[TIME_BITS-1:0]),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  esch_pick #(
    .IDX_W  (IdxW),
    .TIME_W (TIME_BITS)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (pick_clear),
    .en_i       (pick_en),
    .policy_i   (use_edf_q),
    .idx_i      (pidx_q),
    .done_i     (rdata_q.done),
    .deadline_i (rdata_q.deadline),
    .period_i   (rdata_q.period),
    .best_vld_o (best_vld),
    .best_idx_o (best_idx)
  );

endmodule

/* rtl/esch_mod_unit.sv */
// ----------------------------------------------------------------------------
// esch_mod_unit
// bit-serial restoring remainder of the tick count by a task period
// ----------------------------------------------------------------------------
module esch_mod_unit
  import esch_pkg::*;
#(
  parameter int unsigned DIV_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TICK_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(TICK_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TICK_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;

  // one quotient bit per cycle
  assign shifted = {rem_q, dvd_q[TICK_W-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TICK_W-2:0], 1'b0};
      if (shifted >= {1'b0, div_q}) begin
        rem_d = diff[DIV_W-1:0];
      end else begin
        rem_d = shifted[DIV_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(TICK_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/esch_pick.sv */
// ----------------------------------------------------------------------------
// esch_pick
// running minimum over the scanned task entries under the chosen policy
// ----------------------------------------------------------------------------
module esch_pick
  import esch_pkg::*;
#(
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned TIME_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              en_i,
  input  logic              policy_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic              done_i,
  input  logic [TIME_W-1:0] deadline_i,
  input  logic [TIME_W-1:0] period_i,
  output logic              best_vld_o,
  output logic [IDX_W-1:0]  best_idx_o
);

  logic              vld_q, vld_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TIME_W-1:0] key_q, key_d;
  logic [TIME_W-1:0] key;
  logic              better;

  assign key = (policy_i == POLICY_EDF) ? deadline_i : period_i;

  // edf: later entry wins ties; rm: earlier entry wins ties
  always_comb begin
    if (policy_i == POLICY_EDF) begin
      better = key <= key_q;
    end else begin
      better = key < key_q;
    end
  end

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    key_d = key_q;
    if (clear_i) begin
      vld_d = 1'b0;
    end else if (en_i && !done_i && (!vld_q || better)) begin
      vld_d = 1'b1;
      idx_d = idx_i;
      key_d = key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
  end

  assign best_vld_o = vld_q;
  assign best_idx_o = idx_q;

endmodule
